// File: hw/rtl/vvc_pkg.sv
`default_nettype none

package vvc_pkg;

    localparam int CFG_DATA_W   = 60;
    localparam int CFG_INDEX_W  = 3;
    localparam int CAMERA_W     = 60;
    localparam int NORMAL_REG_W = 48;
    localparam int FOG_W        = 19;
    localparam int FOG_SQ_W     = 2 * FOG_W;
    localparam int MODE_W       = 2;
    localparam int PLANE_COUNT  = 5;
    localparam int AXES         = 3;
    localparam int QUEUE_DEPTH  = 4;
    localparam int OUT_DEPTH    = 4;
    localparam int OUT_COUNT_W  = $clog2(OUT_DEPTH + 1);

    localparam int MODE_FOG_BIT     = 0;
    localparam int MODE_SUBJECT_BIT = 1;
    localparam logic [MODE_W-1:0] MODE_RESET = 2'd2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CAMERA   = 3'd0,
        REG_NORMAL_0 = 3'd1,
        REG_NORMAL_1 = 3'd2,
        REG_NORMAL_2 = 3'd3,
        REG_NORMAL_3 = 3'd4,
        REG_REAR     = 3'd5,
        REG_FOG      = 3'd6,
        REG_MODE     = 3'd7
    } cfg_reg_t;

    typedef enum logic {
        OP_ENTITY = 1'b0,
        OP_VERTEX = 1'b1
    } op_t;

    typedef logic [PLANE_COUNT-1:0] plane_mask_t;
    localparam plane_mask_t MASK_ALL = '1;

    typedef struct packed {
        logic [CAMERA_W-1:0]                      camera;
        logic [PLANE_COUNT-1:0][NORMAL_REG_W-1:0] normal;
        logic [FOG_W-1:0]                         fog_end;
        logic [MODE_W-1:0]                        mode;
    } cfg_t;

    typedef struct packed {
        op_t  op;
        logic subject_ok;
        logic last;
    } ctrl_t;

    typedef struct packed {
        op_t  kind;
        logic verdict;
    } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/vvc_fifo.sv
`default_nettype none

module vvc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic                       pop,
    input  wire logic [WIDTH-1:0]           wdata,
    output logic      [WIDTH-1:0]           rdata,
    output logic                            full,
    output logic                            empty,
    output logic [$clog2(DEPTH+1)-1:0]      count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = store_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= wdata;
    end

endmodule

`default_nettype wire

// File: hw/rtl/vvc_regs.sv
`default_nettype none

module vvc_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [vvc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [vvc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output vvc_pkg::cfg_t                         cfg
);

    import vvc_pkg::*;

    cfg_t cfg_reg, cfg_next;

    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CAMERA:   cfg_next.camera    = cfg_data[CAMERA_W-1:0];
                REG_NORMAL_0: cfg_next.normal[0] = cfg_data[NORMAL_REG_W-1:0];
                REG_NORMAL_1: cfg_next.normal[1] = cfg_data[NORMAL_REG_W-1:0];
                REG_NORMAL_2: cfg_next.normal[2] = cfg_data[NORMAL_REG_W-1:0];
                REG_NORMAL_3: cfg_next.normal[3] = cfg_data[NORMAL_REG_W-1:0];
                REG_REAR:     cfg_next.normal[4] = cfg_data[NORMAL_REG_W-1:0];
                REG_FOG:      cfg_next.fog_end   = cfg_data[FOG_W-1:0];
                REG_MODE:     cfg_next.mode      = cfg_data[MODE_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.camera  <= '0;
            cfg_reg.normal  <= '0;
            cfg_reg.fog_end <= '0;
            cfg_reg.mode    <= MODE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/vvc_front.sv
`default_nettype none

module vvc_front #(
    parameter int CW = 20
) (
    input  wire logic                                 push,
    output logic                                      full,
    input  wire logic                                 operation,
    input  wire logic signed [CW-1:0]                 point_x,
    input  wire logic signed [CW-1:0]                 point_y,
    input  wire logic signed [CW-1:0]                 point_z,
    input  wire logic                                 has_subject,
    input  wire logic                                 last_vertex,
    input  wire logic [vvc_pkg::CAMERA_W-1:0]         camera,
    input  wire logic                                 need_subject,
    input  wire logic                                 q_full,
    output logic                                      q_push,
    output logic [3*(CW+1)+$bits(vvc_pkg::ctrl_t)-1:0] q_data
);

    import vvc_pkg::*;

    logic [3*CW-1:0]   cam_ext;
    logic signed [CW-1:0] cam_x, cam_y, cam_z;
    logic signed [CW:0]   dx, dy, dz;
    ctrl_t                ctrl;

    // camera fields sit x lowest; pad or trim the register to three fields
    assign cam_ext = (3*CW)'(camera);
    assign cam_x   = cam_ext[0 +: CW];
    assign cam_y   = cam_ext[CW +: CW];
    assign cam_z   = cam_ext[2*CW +: CW];

    assign dx = {point_x[CW-1], point_x} - {cam_x[CW-1], cam_x};
    assign dy = {point_y[CW-1], point_y} - {cam_y[CW-1], cam_y};
    assign dz = {point_z[CW-1], point_z} - {cam_z[CW-1], cam_z};

    // classify: entity or vertex, subject rule, aperture close
    assign ctrl.op         = op_t'(operation);
    assign ctrl.subject_ok = !need_subject || has_subject;
    assign ctrl.last       = last_vertex;

    assign full   = q_full;
    assign q_push = push && !q_full;
    assign q_data = {dz, dy, dx, ctrl};

endmodule

`default_nettype wire

// File: hw/rtl/vvc_back.sv
`default_nettype none

module vvc_back #(
    parameter int CW = 20,
    parameter int NW = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire vvc_pkg::cfg_t                        cfg,
    input  wire logic                                 q_empty,
    input  wire logic [3*(CW+1)+$bits(vvc_pkg::ctrl_t)-1:0] q_data,
    output logic                                      q_pop,
    input  wire logic [vvc_pkg::OUT_COUNT_W-1:0]      out_count,
    output logic                                      res_push,
    output vvc_pkg::result_t                          res_data
);

    import vvc_pkg::*;

    localparam int DW    = CW + 1;
    localparam int CTRLW = $bits(ctrl_t);
    localparam int PRW   = DW + NW;
    localparam int DOTW  = PRW + 2;
    localparam int SQW   = 2 * DW;
    localparam int DISTW = SQW + 2;
    localparam int CMPW  = (DISTW > FOG_SQ_W) ? DISTW : FOG_SQ_W;
    localparam int PENDW = OUT_COUNT_W + 1;

    ctrl_t                   head_ctrl;
    logic signed [DW-1:0]    dv [AXES];
    logic [3*NW-1:0]         nrm_ext [PLANE_COUNT];
    logic [PENDW-1:0]        pending;
    logic                    issue;

    // stage 1: products
    logic                    s1_valid_reg;
    ctrl_t                   s1_ctrl_reg;
    logic signed [PRW-1:0]   s1_prod_reg [PLANE_COUNT][AXES];
    logic signed [PRW-1:0]   s1_prod_next [PLANE_COUNT][AXES];
    logic [SQW-1:0]          s1_sq_reg [AXES];
    logic signed [SQW-1:0]   s1_sq_next [AXES];
    logic [FOG_SQ_W-1:0]     s1_fog_sq_reg;

    // stage 2: plane mask and fog decision
    logic signed [DOTW-1:0]  dot [PLANE_COUNT];
    plane_mask_t             s2_mask_next;
    logic [CMPW-1:0]         dist_sq;
    logic                    s2_sel_next;
    logic                    s2_valid_reg;
    ctrl_t                   s2_ctrl_reg;
    plane_mask_t             s2_mask_reg;
    logic                    s2_sel_reg;

    // aperture state
    plane_mask_t             planes_reg, planes_next;
    plane_mask_t             fold;

    assign head_ctrl = q_data[CTRLW-1:0];

    // hold issue while the result queue could overflow with items in flight
    assign pending = {1'b0, out_count} + PENDW'(s1_valid_reg) + PENDW'(s2_valid_reg);
    assign issue   = !q_empty && (pending < PENDW'(OUT_DEPTH));
    assign q_pop   = issue;

    genvar p, k;
    generate
        for (k = 0; k < AXES; k++)
        begin : g_axis
            assign dv[k] = q_data[CTRLW + k*DW +: DW];
            assign s1_sq_next[k] = SQW'(dv[k]) * SQW'(dv[k]);
        end
        for (p = 0; p < PLANE_COUNT; p++)
        begin : g_plane
            assign nrm_ext[p] = (3*NW)'(cfg.normal[p]);
            for (k = 0; k < AXES; k++)
            begin : g_term
                logic signed [NW-1:0] nv;
                assign nv = nrm_ext[p][k*NW +: NW];
                assign s1_prod_next[p][k] = PRW'(dv[k]) * PRW'(nv);
            end
            assign dot[p] = DOTW'(s1_prod_reg[p][0]) + DOTW'(s1_prod_reg[p][1])
                          + DOTW'(s1_prod_reg[p][2]);
            assign s2_mask_next[p] = !dot[p][DOTW-1] && (dot[p] != '0);
        end
    endgenerate

    assign dist_sq = CMPW'(s1_sq_reg[0]) + CMPW'(s1_sq_reg[1]) + CMPW'(s1_sq_reg[2]);
    assign s2_sel_next = s1_ctrl_reg.subject_ok
                       && (!cfg.mode[MODE_FOG_BIT] || (dist_sq < CMPW'(s1_fog_sq_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            planes_reg   <= MASK_ALL;
        end
        else
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            planes_reg   <= planes_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ctrl_reg   <= head_ctrl;
        s1_prod_reg   <= s1_prod_next;
        for (int i = 0; i < AXES; i++)
            s1_sq_reg[i] <= SQW'(s1_sq_next[i]);
        s1_fog_sq_reg <= FOG_SQ_W'(cfg.fog_end) * FOG_SQ_W'(cfg.fog_end);
        s2_ctrl_reg   <= s1_ctrl_reg;
        s2_mask_reg   <= s2_mask_next;
        s2_sel_reg    <= s2_sel_next;
    end

    // stage 3: fold vertices, emit verdicts
    assign fold = planes_reg & s2_mask_reg;

    always_comb
    begin
        res_push         = s2_valid_reg
                         && ((s2_ctrl_reg.op == OP_ENTITY) || s2_ctrl_reg.last);
        res_data.kind    = s2_ctrl_reg.op;
        res_data.verdict = (s2_ctrl_reg.op == OP_ENTITY)
                         ? (s2_sel_reg && (s2_mask_reg == '0))
                         : (fold == '0);
        planes_next = planes_reg;
        if (s2_valid_reg && (s2_ctrl_reg.op == OP_VERTEX))
            planes_next = s2_ctrl_reg.last ? MASK_ALL : fold;
    end

endmodule

`default_nettype wire

// File: hw/rtl/view_volume_cull_test.sv
// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+-----------------------------------------
// cfg       | in        | cfg_write              | cfg_index, cfg_data
// item      | in        | push / full            | operation, point_x/y/z, has_subject,
//           |           |                        | last_vertex
// result    | out       | empty / pop            | verdict, verdict_kind
//
// One item per cycle sustained while results are popped. An entity or a closing vertex
// shows its result after the input queue, product stage, plane sum and compare stage,
// then the result queue. Issue from the input queue holds while the result queue
// plus the two arithmetic stages would exceed the result queue depth; full rises only
// once the input queue holds four items. Reset clears both queues, the pipeline
// valids, sets the aperture mask to all planes, and loads the register defaults.
`default_nettype none

module view_volume_cull_test #(
    parameter int COORD_WIDTH  = 20,
    parameter int NORMAL_WIDTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [vvc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [vvc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic                             operation,
    input  wire logic signed [COORD_WIDTH-1:0]    point_x,
    input  wire logic signed [COORD_WIDTH-1:0]    point_y,
    input  wire logic signed [COORD_WIDTH-1:0]    point_z,
    input  wire logic                             has_subject,
    input  wire logic                             last_vertex,
    output logic                                  empty,
    input  wire logic                             pop,
    output logic                                  verdict,
    output logic                                  verdict_kind
);

    import vvc_pkg::*;

    localparam int RECW = 3 * (COORD_WIDTH + 1) + $bits(ctrl_t);

    cfg_t                   cfg;
    logic                   q_full, q_empty, q_push, q_pop;
    logic [RECW-1:0]        q_wdata, q_rdata;
    logic [OUT_COUNT_W-1:0] out_count;
    logic                   res_push;
    result_t                res_data, res_head;

    vvc_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vvc_front #(
        .CW (COORD_WIDTH)
    ) u_front (
        .push         (push),
        .full         (full),
        .operation    (operation),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .has_subject  (has_subject),
        .last_vertex  (last_vertex),
        .camera       (cfg.camera),
        .need_subject (cfg.mode[MODE_SUBJECT_BIT]),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_wdata)
    );

    vvc_fifo #(
        .WIDTH (RECW),
        .DEPTH (QUEUE_DEPTH)
    ) u_item_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .pop   (q_pop),
        .wdata (q_wdata),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty),
        .count ()
    );

    vvc_back #(
        .CW (COORD_WIDTH),
        .NW (NORMAL_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .out_count (out_count),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    vvc_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .pop   (pop),
        .wdata (res_data),
        .rdata (res_head),
        .full  (),
        .empty (empty),
        .count (out_count)
    );

    assign verdict      = res_head.verdict;
    assign verdict_kind = res_head.kind;

endmodule

`default_nettype wire

// File: hw/rtl/vvc_checker.sv
`default_nettype none

module vvc_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic push,
    input wire logic full,
    input wire logic empty,
    input wire logic pop,
    input wire logic verdict,
    input wire logic verdict_kind
);

    // no result can reach the port after leaving reset before an item could pass the pipe
    a_empty_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> empty ##1 empty ##1 empty)
        else $error("result shown too soon after reset");

    // input queue needs four items before it reports full
    a_not_full_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !full ##1 !full ##1 !full ##1 !full)
        else $error("full raised too soon after reset");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(verdict) && $stable(verdict_kind)))
        else $error("waiting result changed or vanished");

endmodule

bind view_volume_cull_test vvc_checker u_checker (.*);

`default_nettype wire

// File: sim/tb_view_volume_cull_test.sv
`default_nettype none

module tb_view_volume_cull_test;
    timeunit 1ns;
    timeprecision 1ps;

    import vvc_pkg::*;

    localparam int COORD_W      = 20;
    localparam int NRM_W        = 16;
    localparam int SETTLE       = 16;
    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 120;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 160;
    localparam int PHASE_SETTING [PHASES] = '{1, 2, 5, 3, 1, 6, 4, 2, 7};

    typedef struct packed {
        op_t                        op;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
        logic                       subj;
        logic                       last;
    } item_t;

    // setting 0 is the reset state; typed rows carry the verdict they must give
    typedef struct packed {
        logic [2:0]                 setting;
        op_t                        op;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
        logic                       subj;
        logic                       last;
        logic                       typed;
        logic                       vtyped;
    } row_t;

    localparam int DIRECTED_LEN = 25;
    localparam row_t DIRECTED [DIRECTED_LEN] = '{
        '{0, OP_ENTITY, 0, 0, 0, 1, 0, 1, 1},
        '{0, OP_ENTITY, 524287, 524287, 524287, 0, 1, 1, 0},
        '{0, OP_ENTITY, -524288, -524288, -524288, 1, 0, 1, 1},
        '{0, OP_VERTEX, -524288, -524288, -524288, 0, 0, 0, 0},
        '{0, OP_VERTEX, 524287, 524287, 524287, 1, 1, 1, 1},
        '{0, OP_VERTEX, 0, 0, 0, 1, 1, 1, 1},
        '{1, OP_ENTITY, 2560, -1280, 7680, 1, 0, 0, 0},
        '{1, OP_ENTITY, 2560, -1280, 7680, 0, 0, 1, 0},
        '{1, OP_ENTITY, 2560, -1280, 40000, 1, 1, 0, 0},
        '{1, OP_ENTITY, 2560, -1280, 5120, 1, 0, 0, 0},
        '{1, OP_ENTITY, 2560, -1280, 2560, 1, 0, 0, 0},
        '{1, OP_ENTITY, -17440, -1280, 7680, 1, 0, 0, 0},
        '{1, OP_VERTEX, -7440, -6280, 10120, 0, 0, 0, 0},
        '{1, OP_VERTEX, 12560, -6280, 10120, 1, 0, 0, 0},
        '{1, OP_VERTEX, 12560, 3720, 10120, 0, 0, 0, 0},
        '{1, OP_VERTEX, -7440, 3720, 10120, 1, 1, 0, 0},
        '{1, OP_VERTEX, -440, -4280, 1000, 0, 0, 0, 0},
        '{1, OP_VERTEX, 5560, -4280, 1000, 0, 0, 0, 0},
        '{1, OP_VERTEX, 5560, 1720, 1000, 0, 0, 0, 0},
        '{1, OP_VERTEX, -440, 1720, 1000, 0, 1, 0, 0},
        '{3, OP_ENTITY, 524287, 524287, 524287, 1, 0, 0, 0},
        '{3, OP_ENTITY, -524288, -524288, -524288, 0, 1, 0, 0},
        '{3, OP_VERTEX, -524288, -524288, -524288, 1, 0, 0, 0},
        '{3, OP_VERTEX, 524287, 524287, 524287, 0, 1, 0, 0},
        '{4, OP_ENTITY, -524288, -524288, -524288, 1, 0, 1, 0}
    };

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]       cfg_data = '0;
    logic                        push = 1'b0;
    logic                        full;
    logic                        operation = 1'b0;
    logic signed [COORD_W-1:0]   point_x = '0;
    logic signed [COORD_W-1:0]   point_y = '0;
    logic signed [COORD_W-1:0]   point_z = '0;
    logic                        has_subject = 1'b0;
    logic                        last_vertex = 1'b0;
    logic                        empty;
    logic                        pop = 1'b0;
    logic                        verdict;
    logic                        verdict_kind;

    // predictor copy of the registers and the aperture mask
    logic [CAMERA_W-1:0]         cam_reg = '0;
    logic [NORMAL_REG_W-1:0]     nrm_reg [PLANE_COUNT] = '{default: '0};
    logic [FOG_W-1:0]            fog_reg = '0;
    logic [MODE_W-1:0]           mode_reg = MODE_RESET;
    plane_mask_t                 aperture_out = MASK_ALL;

    result_t                     verdicts_due [$];
    int                          errors = 0;
    int                          burst_left = 0;
    bit                          steady = 1'b0;
    bit                          hold_req = 1'b0;
    int                          idle_cycles = 0;

    view_volume_cull_test #(
        .COORD_WIDTH  (COORD_W),
        .NORMAL_WIDTH (NRM_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .operation    (operation),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .has_subject  (has_subject),
        .last_vertex  (last_vertex),
        .empty        (empty),
        .pop          (pop),
        .verdict      (verdict),
        .verdict_kind (verdict_kind)
    );

    always #5 clk = ~clk;

    function automatic logic signed [COORD_W-1:0] cam_axis(input int k);
        return cam_reg[k*COORD_W +: COORD_W];
    endfunction

    function automatic logic [CAMERA_W-1:0] pack_coord(input int x, input int y, input int z);
        return {COORD_W'(z), COORD_W'(y), COORD_W'(x)};
    endfunction

    function automatic logic [NORMAL_REG_W-1:0] pack_normal(input int x, input int y, input int z);
        return {NRM_W'(z), NRM_W'(y), NRM_W'(x)};
    endfunction

    // planes with the point strictly outside, and squared distance to the camera
    function automatic void probe_point(input item_t it, output plane_mask_t outside,
                                        output longint dist2);
        longint d [AXES];
        longint acc;
        d[0] = longint'(it.x) - longint'(cam_axis(0));
        d[1] = longint'(it.y) - longint'(cam_axis(1));
        d[2] = longint'(it.z) - longint'(cam_axis(2));
        outside = '0;
        for (int i = 0; i < PLANE_COUNT; i++)
        begin
            acc = 0;
            for (int k = 0; k < AXES; k++)
                acc += d[k] * longint'($signed(nrm_reg[i][k*NRM_W +: NRM_W]));
            outside[i] = (acc > 0);
        end
        dist2 = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
    endfunction

    task automatic predict_verdict(input item_t it, input logic typed, input logic vtyped);
        plane_mask_t outside;
        longint      dist2;
        longint      fe;
        logic        sel;
        result_t     res;
        probe_point(it, outside, dist2);
        if (it.op == OP_ENTITY)
        begin
            sel = !mode_reg[MODE_SUBJECT_BIT] || it.subj;
            if (sel && mode_reg[MODE_FOG_BIT])
            begin
                fe = longint'(fog_reg);
                sel = dist2 < fe * fe;
            end
            if (sel)
                sel = (outside == '0);
            res.kind = OP_ENTITY;
            res.verdict = typed ? vtyped : sel;
            verdicts_due = {verdicts_due, res};
        end
        else
        begin
            aperture_out &= outside;
            if (it.last)
            begin
                res.kind = OP_VERTEX;
                res.verdict = typed ? vtyped : (aperture_out == '0);
                verdicts_due = {verdicts_due, res};
                aperture_out = MASK_ALL;
            end
        end
    endtask

    // called right after the clock rises; returns once the queue takes the item
    task automatic offer(input item_t it, input logic typed, input logic vtyped);
        push        <= 1'b1;
        operation   <= it.op;
        point_x     <= it.x;
        point_y     <= it.y;
        point_z     <= it.z;
        has_subject <= it.subj;
        last_vertex <= it.last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_verdict(it, typed, vtyped);
    endtask

    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = steady ? 0 : $urandom_range(0, 9);
            if (gap != 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // hold input until every verdict is back and the pipe has flushed
    task automatic drain_results();
        push <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_CAMERA: cam_reg = val[CAMERA_W-1:0];
            REG_FOG:    fog_reg = val[FOG_W-1:0];
            REG_MODE:   mode_reg = val[MODE_W-1:0];
            default:    nrm_reg[int'(idx) - int'(REG_NORMAL_0)] = val[NORMAL_REG_W-1:0];
        endcase
    endtask

    task automatic load_setting(input int s);
        logic [CFG_DATA_W-1:0] vals [8];
        logic [63:0]           raw;
        case (s)
            1, 2:
            begin
                // frustum looking down +z, 90 degree opening
                vals[0] = (s == 1) ? pack_coord(2560, -1280, 5120)
                                   : pack_coord(-3000, 700, -9000);
                vals[1] = pack_normal(-11585, 0, -11585);
                vals[2] = pack_normal(11585, 0, -11585);
                vals[3] = pack_normal(0, -11585, -11585);
                vals[4] = pack_normal(0, 11585, -11585);
                vals[5] = pack_normal(0, 0, -16384);
                vals[6] = (s == 1) ? 60'd25600 : 60'd8000;
                vals[7] = (s == 1) ? 60'd3 : 60'd0;
            end
            3:
            begin
                vals[0] = {3{20'h7FFFF}};
                for (int i = 1; i < 5; i++)
                    vals[i] = {3{16'h7FFF}};
                vals[5] = {3{16'h8000}};
                vals[6] = 60'h7FFFF;
                vals[7] = 60'd3;
            end
            4:
            begin
                vals[0] = {3{20'h80000}};
                for (int i = 1; i < 5; i++)
                    vals[i] = {3{16'h8000}};
                vals[5] = {3{16'h7FFF}};
                vals[6] = 60'd0;
                vals[7] = 60'd1;
            end
            default:
            begin
                // garbage above each register's width must be dropped
                for (int i = 0; i < 8; i++)
                begin
                    raw = {$urandom, $urandom};
                    vals[i] = raw[CFG_DATA_W-1:0];
                end
                if ($urandom_range(0, 2) != 0)
                    vals[0] = pack_coord(int'($urandom_range(0, 8192)) - 4096,
                                         int'($urandom_range(0, 8192)) - 4096,
                                         int'($urandom_range(0, 8192)) - 4096);
            end
        endcase
        for (int i = 0; i < 8; i++)
            write_reg(cfg_reg_t'(i), vals[i]);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic signed [COORD_W-1:0] near(input logic signed [COORD_W-1:0] base,
                                                        input int reach);
        logic [31:0]               raw;
        logic signed [COORD_W-1:0] pt;
        int                        r;
        raw = $urandom;
        case (reach)
            0:       r = 512;
            1:       r = 8192;
            2:       r = 65536;
            default: r = 0;
        endcase
        if (r == 0)
            pt = raw[COORD_W-1:0];
        else
            pt = base + COORD_W'(int'($urandom_range(0, 2 * r)) - r);
        return pt;
    endfunction

    task automatic run_random(input int count, input int hold_at, input int drain_at);
        item_t it;
        item_t center;
        int    n;
        int    pick;
        int    reach;
        int    spread;
        int    nv;
        n = 0;
        while (n < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                reach   = $urandom_range(0, 3);
                it.op   = OP_ENTITY;
                it.x    = near(cam_axis(0), reach);
                it.y    = near(cam_axis(1), reach);
                it.z    = near(cam_axis(2), reach);
                it.subj = $urandom_range(0, 1);
                it.last = $urandom_range(0, 1);
                pace();
                offer(it, 1'b0, 1'b0);
                n++;
            end
            else if (pick < 85)
            begin
                // aperture: mostly four vertices around one spot
                nv       = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 4;
                reach    = $urandom_range(0, 2);
                spread   = $urandom_range(0, 1);
                center.x = near(cam_axis(0), reach);
                center.y = near(cam_axis(1), reach);
                center.z = near(cam_axis(2), reach);
                for (int v = 0; v < nv; v++)
                begin
                    it.op   = OP_VERTEX;
                    it.x    = near(center.x, spread);
                    it.y    = near(center.y, spread);
                    it.z    = near(center.z, spread);
                    it.subj = $urandom_range(0, 1);
                    it.last = (v == nv - 1);
                    pace();
                    offer(it, 1'b0, 1'b0);
                    n++;
                end
            end
            else
            begin
                it.op   = op_t'($urandom_range(0, 1));
                it.x    = near('0, 3);
                it.y    = near('0, 3);
                it.z    = near('0, 3);
                it.subj = $urandom_range(0, 1);
                it.last = $urandom_range(0, 1);
                pace();
                offer(it, 1'b0, 1'b0);
                n++;
            end
            if (n >= hold_at && hold_at >= 0)
            begin
                hold_req = 1'b1;
                hold_at = -1;
            end
            if (n >= drain_at && drain_at >= 0)
            begin
                drain_results();
                drain_at = -1;
            end
        end
    endtask

    // result side: check each taken verdict, then pick pop for the next cycle
    initial
    begin
        result_t want;
        int      style;
        int      style_left;
        int      hold_left;
        style = 0;
        style_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (verdicts_due.size() == 0)
                begin
                    $error("verdict: no verdict expected, got %0d", verdict);
                    errors++;
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (verdict_kind !== want.kind)
                    begin
                        $error("verdict_kind: expected %0d, got %0d", want.kind, verdict_kind);
                        errors++;
                    end
                    if (verdict !== want.verdict)
                    begin
                        $error("verdict: expected %0d, got %0d", want.verdict, verdict);
                        errors++;
                    end
                end
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (style_left == 0)
            begin
                style = $urandom_range(0, 2);
                style_left = $urandom_range(50, 300);
            end
            style_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (style == 0)
                pop <= 1'b1;
            else if (style == 1)
                pop <= $urandom_range(0, 1);
            else
                pop <= ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("view_volume_cull_test test failed");
                $finish;
            end
        end
    end

    initial
    begin
        item_t it;
        int    cur_setting;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        cur_setting = 0;

        for (int r = 0; r < DIRECTED_LEN; r++)
        begin
            if (int'(DIRECTED[r].setting) != cur_setting)
            begin
                drain_results();
                cur_setting = DIRECTED[r].setting;
                load_setting(cur_setting);
            end
            it.op   = DIRECTED[r].op;
            it.x    = DIRECTED[r].x;
            it.y    = DIRECTED[r].y;
            it.z    = DIRECTED[r].z;
            it.subj = DIRECTED[r].subj;
            it.last = DIRECTED[r].last;
            pace();
            offer(it, DIRECTED[r].typed, DIRECTED[r].vtyped);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            load_setting(PHASE_SETTING[p]);
            steady = (p % 3 == 2);
            burst_left = 0;
            run_random(PHASE_ITEMS, (p == 1 || p == 5) ? 40 : -1, (p == 3) ? 80 : -1);
        end

        drain_results();
        if (errors == 0)
            $display("view_volume_cull_test test passed");
        else
            $display("view_volume_cull_test test failed");
        $finish;
    end

endmodule

`default_nettype wire
